// ----- design/tdf_pkg.sv -----
// Package with the sizes, codes and control types of the table-driven state machine.
`default_nettype none
package tdf_pkg;

    // Table sizes and state width.
    localparam int EVENT_ENTRIES = 16;
    localparam int TIMED_ENTRIES = 8;
    localparam int STATE_BITS    = 4;
    localparam int MAX_RESULTS   = 10;

    // Derived index and count widths.
    localparam int EV_IW = (EVENT_ENTRIES > 1) ? $clog2(EVENT_ENTRIES) : 1;
    localparam int EV_CW = $clog2(EVENT_ENTRIES + 1);
    localparam int TM_IW = (TIMED_ENTRIES > 1) ? $clog2(TIMED_ENTRIES) : 1;
    localparam int TM_CW = $clog2(TIMED_ENTRIES + 1);
    localparam int RC_W  = $clog2(MAX_RESULTS + 1);

    // Input actions.
    localparam logic [1:0] ACT_RUN     = 2'd0;
    localparam logic [1:0] ACT_TRIGGER = 2'd1;
    localparam logic [1:0] ACT_ADD_EV  = 2'd2;
    localparam logic [1:0] ACT_ADD_TM  = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_ACTIV = 2'd1;
    localparam logic [1:0] KIND_TRANS = 2'd2;

    // Register indexes.
    localparam logic REG_START_STATE = 1'b0;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ACT,
        ST_TSCAN,
        ST_ESCAN,
        ST_FLUSH
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic accept;
        logic start;
        logic activity;
        logic tstep;
        logic estep;
        logic flush;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic started;
        logic can_emit;
        logic out_free;
        logic pend_v;
        logic t_done;
        logic e_done;
        logic e_match;
    } t_sts;

endpackage
`default_nettype wire

// ----- design/tdf_ctrl.sv -----
// Controller state machine that sequences one input item at a time.
`default_nettype none
module tdf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_action,
    output logic               o_ready,
    input  wire tdf_pkg::t_sts i_sts,
    output tdf_pkg::t_cmd      o_cmd
);

    tdf_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            tdf_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_action == tdf_pkg::ACT_RUN) begin
                        n_state = tdf_pkg::ST_START;
                    end else if (i_action == tdf_pkg::ACT_TRIGGER && i_sts.started) begin
                        n_state = tdf_pkg::ST_ESCAN;
                    end
                end
            end
            tdf_pkg::ST_START: begin
                if (i_sts.can_emit) begin
                    o_cmd.start = 1'b1;
                    n_state = tdf_pkg::ST_ACT;
                end
            end
            tdf_pkg::ST_ACT: begin
                if (i_sts.can_emit) begin
                    o_cmd.activity = 1'b1;
                    n_state = tdf_pkg::ST_TSCAN;
                end
            end
            tdf_pkg::ST_TSCAN: begin
                if (i_sts.t_done) begin
                    n_state = tdf_pkg::ST_FLUSH;
                end else if (i_sts.can_emit) begin
                    o_cmd.tstep = 1'b1;
                end
            end
            tdf_pkg::ST_ESCAN: begin
                if (i_sts.e_done) begin
                    n_state = tdf_pkg::ST_FLUSH;
                end else if (i_sts.can_emit) begin
                    o_cmd.estep = 1'b1;
                    if (i_sts.e_match) begin
                        n_state = tdf_pkg::ST_FLUSH;
                    end
                end
            end
            tdf_pkg::ST_FLUSH: begin
                if (!i_sts.pend_v) begin
                    n_state = tdf_pkg::ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = tdf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/tdf_dp.sv -----
// Datapath: transition tables, timers, current state and result registers.
`default_nettype none
module tdf_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tdf_pkg::t_cmd i_cmd,
    output tdf_pkg::t_sts      o_sts,
    // Fields of the item in transfer
    input  wire logic [1:0]    i_action,
    input  wire logic [31:0]   i_time_now,
    input  wire logic [7:0]    i_event_code,
    input  wire logic [3:0]    i_from_state,
    input  wire logic [3:0]    i_to_state,
    input  wire logic [31:0]   i_interval,
    // Configuration write and read back
    input  wire logic          i_cfg_we,
    input  wire logic [3:0]    i_cfg_wdata,
    output logic [3:0]         o_start_state,
    // Result register
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_kind,
    output logic [3:0]         o_left_state,
    output logic [3:0]         o_entered_state,
    output logic [3:0]         o_entry_index,
    output logic               o_was_timed,
    output logic               o_last
);

    localparam int SB = tdf_pkg::STATE_BITS;

    logic [3:0]                    r_init;
    logic                          r_started;
    logic [SB-1:0]                 r_cur;
    logic [31:0]                   r_now;
    logic [7:0]                    r_code;
    logic [SB-1:0]                 r_ev_from [tdf_pkg::EVENT_ENTRIES];
    logic [SB-1:0]                 r_ev_to   [tdf_pkg::EVENT_ENTRIES];
    logic [7:0]                    r_ev_code [tdf_pkg::EVENT_ENTRIES];
    logic [tdf_pkg::EV_CW-1:0]     r_ev_cnt;
    logic [SB-1:0]                 r_tm_from [tdf_pkg::TIMED_ENTRIES];
    logic [SB-1:0]                 r_tm_to   [tdf_pkg::TIMED_ENTRIES];
    logic [31:0]                   r_tm_ivl  [tdf_pkg::TIMED_ENTRIES];
    logic [31:0]                   r_start   [tdf_pkg::TIMED_ENTRIES];
    logic [tdf_pkg::TM_CW-1:0]     r_tm_cnt;
    logic [tdf_pkg::TM_CW-1:0]     r_tidx;
    logic [tdf_pkg::EV_CW-1:0]     r_eidx;
    logic [tdf_pkg::RC_W-1:0]      r_rcnt;
    // Pending result, held until it is known whether another follows
    logic                          r_p_v;
    logic [1:0]                    r_p_kind;
    logic [3:0]                    r_p_left;
    logic [3:0]                    r_p_ent;
    logic [3:0]                    r_p_idx;
    logic                          r_p_timed;
    // Output register
    logic                          r_o_v;
    logic [1:0]                    r_o_kind;
    logic [3:0]                    r_o_left;
    logic [3:0]                    r_o_ent;
    logic [3:0]                    r_o_idx;
    logic                          r_o_timed;
    logic                          r_o_last;

    logic [tdf_pkg::TM_IW-1:0] ti;
    logic [tdf_pkg::EV_IW-1:0] ei;
    logic                      out_free, t_sel, t_fire, e_match;
    logic                      emit, emit_kept, push, take;
    logic [SB-1:0]             take_to;
    logic [1:0]                e_kind;
    logic [3:0]                e_left, e_ent, e_idx;
    logic                      e_timed;
    logic [31:0]               elapsed;

    assign ti       = r_tidx[tdf_pkg::TM_IW-1:0];
    assign ei       = r_eidx[tdf_pkg::EV_IW-1:0];
    assign out_free = !r_o_v || i_out_ready;
    assign elapsed  = r_now - r_start[ti];
    assign t_sel    = (r_tm_from[ti] == r_cur);
    assign t_fire   = t_sel && (r_start[ti] != 32'd0) && (elapsed >= r_tm_ivl[ti]);
    assign e_match  = (r_ev_from[ei] == r_cur) && (r_ev_code[ei] == r_code);

    // Result and transition selection for this cycle.
    always_comb begin
        emit    = 1'b0;
        take    = 1'b0;
        take_to = r_tm_to[ti];
        e_kind  = tdf_pkg::KIND_ACTIV;
        e_left  = 4'(r_cur);
        e_ent   = 4'(r_cur);
        e_idx   = 4'd0;
        e_timed = 1'b0;
        if (i_cmd.start && !r_started) begin
            emit   = 1'b1;
            e_kind = tdf_pkg::KIND_INIT;
            e_left = 4'(SB'(r_init));
            e_ent  = 4'(SB'(r_init));
        end else if (i_cmd.activity) begin
            emit = 1'b1;
        end else if (i_cmd.tstep && t_fire) begin
            emit    = 1'b1;
            take    = 1'b1;
            e_kind  = tdf_pkg::KIND_TRANS;
            e_ent   = 4'(r_tm_to[ti]);
            e_idx   = 4'(ti);
            e_timed = 1'b1;
        end else if (i_cmd.estep && e_match) begin
            emit    = 1'b1;
            take    = 1'b1;
            take_to = r_ev_to[ei];
            e_kind  = tdf_pkg::KIND_TRANS;
            e_ent   = 4'(r_ev_to[ei]);
            e_idx   = 4'(ei);
        end
    end

    assign emit_kept = emit && (r_rcnt < tdf_pkg::RC_W'(tdf_pkg::MAX_RESULTS));
    assign push      = r_p_v && (emit_kept || i_cmd.flush);

    // Machine state, tables and timers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= 4'd0;
            r_started <= 1'b0;
            r_cur     <= '0;
            r_ev_cnt  <= '0;
            r_tm_cnt  <= '0;
            for (int j = 0; j < tdf_pkg::TIMED_ENTRIES; j++) begin
                r_start[j] <= 32'd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_init <= i_cfg_wdata;
            end
            // Appends are done at the transfer itself.
            if (i_cmd.accept && i_action == tdf_pkg::ACT_ADD_EV
                && r_ev_cnt < tdf_pkg::EV_CW'(tdf_pkg::EVENT_ENTRIES)) begin
                r_ev_from[r_ev_cnt[tdf_pkg::EV_IW-1:0]] <= SB'(i_from_state);
                r_ev_to[r_ev_cnt[tdf_pkg::EV_IW-1:0]]   <= SB'(i_to_state);
                r_ev_code[r_ev_cnt[tdf_pkg::EV_IW-1:0]] <= i_event_code;
                r_ev_cnt <= r_ev_cnt + 1'b1;
            end
            if (i_cmd.accept && i_action == tdf_pkg::ACT_ADD_TM
                && r_tm_cnt < tdf_pkg::TM_CW'(tdf_pkg::TIMED_ENTRIES)) begin
                r_tm_from[r_tm_cnt[tdf_pkg::TM_IW-1:0]] <= SB'(i_from_state);
                r_tm_to[r_tm_cnt[tdf_pkg::TM_IW-1:0]]   <= SB'(i_to_state);
                r_tm_ivl[r_tm_cnt[tdf_pkg::TM_IW-1:0]]  <= i_interval;
                r_start[r_tm_cnt[tdf_pkg::TM_IW-1:0]]   <= 32'd0;
                r_tm_cnt <= r_tm_cnt + 1'b1;
            end
            // First run enters the initial state.
            if (i_cmd.start && !r_started) begin
                r_started <= 1'b1;
                r_cur     <= SB'(r_init);
            end
            // An unarmed timer of the current state is armed with now.
            if (i_cmd.tstep && t_sel && r_start[ti] == 32'd0) begin
                r_start[ti] <= r_now;
            end
            // A transition re-arms every timer of the new state.
            if (take) begin
                r_cur <= take_to;
                for (int j = 0; j < tdf_pkg::TIMED_ENTRIES; j++) begin
                    if (tdf_pkg::TM_CW'(j) < r_tm_cnt && r_tm_from[j] == take_to) begin
                        r_start[j] <= r_now;
                    end
                end
            end
            // The timer that fired is disarmed last.
            if (i_cmd.tstep && t_fire) begin
                r_start[ti] <= 32'd0;
            end
        end
    end

    // Scan indexes and the latched item fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_now  <= i_time_now;
            r_code <= i_event_code;
            r_tidx <= '0;
            r_eidx <= '0;
        end else begin
            if (i_cmd.tstep) begin
                r_tidx <= r_tidx + 1'b1;
            end
            if (i_cmd.estep) begin
                r_eidx <= r_eidx + 1'b1;
            end
        end
    end

    // Pending result and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v  <= 1'b0;
            r_o_v  <= 1'b0;
            r_rcnt <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_rcnt <= '0;
            end else if (emit_kept) begin
                r_rcnt <= r_rcnt + 1'b1;
            end
            if (emit_kept) begin
                r_p_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_p_v <= 1'b0;
            end
            if (push) begin
                r_o_v <= 1'b1;
            end else if (i_out_ready) begin
                r_o_v <= 1'b0;
            end
        end
        if (emit_kept) begin
            r_p_kind  <= e_kind;
            r_p_left  <= e_left;
            r_p_ent   <= e_ent;
            r_p_idx   <= e_idx;
            r_p_timed <= e_timed;
        end
        if (push) begin
            r_o_kind  <= r_p_kind;
            r_o_left  <= r_p_left;
            r_o_ent   <= r_p_ent;
            r_o_idx   <= r_p_idx;
            r_o_timed <= r_p_timed;
            r_o_last  <= i_cmd.flush;
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.started  = r_started;
        o_sts.can_emit = !r_p_v || out_free;
        o_sts.out_free = out_free;
        o_sts.pend_v   = r_p_v;
        o_sts.t_done   = (r_tidx >= r_tm_cnt);
        o_sts.e_done   = (r_eidx >= r_ev_cnt);
        o_sts.e_match  = e_match;
    end

    assign o_start_state   = r_init;
    assign o_out_valid     = r_o_v;
    assign o_kind          = r_o_kind;
    assign o_left_state    = r_o_left;
    assign o_entered_state = r_o_ent;
    assign o_entry_index   = r_o_idx;
    assign o_was_timed     = r_o_timed;
    assign o_last          = r_o_last;

endmodule
`default_nettype wire

// ----- design/table_driven_fsm_with_timed_transitions.sv -----
// Top level of the programmable table-driven state machine with timed transitions.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tuser: action; tdata: time, code, from, to, interval
// m_       out  m_tvalid/m_tready  tuser: kind; tlast: last; tdata: left, entered, index, timed
// apb      in   psel/penable       start state register at byte address 0
//
// An append or an ignored trigger leaves the controller in idle. A trigger scans the event
// table entry by entry, stopping at the first match or at the end of the table, then flushes.
// A run item goes through start, activity, the single shared scan over the timed table and flush.
// Reset is synchronous and clears counters, timers, the started flag and the outputs.
// While a result waits and the output register is still full, the sequence holds.
`default_nettype none
module table_driven_fsm_with_timed_transitions (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tuser: action[1:0]
    input  wire logic [1:0]  s_tuser,
    // tdata: time_now[31:0], event_code[39:32], from_state[43:40], to_state[47:44],
    //        interval[79:48]
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tuser: kind[1:0]
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    // tdata: left_state[3:0], entered_state[7:4], entry_index[11:8], was_timed[12], zeros
    output logic [15:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    tdf_pkg::t_cmd cmd;
    tdf_pkg::t_sts sts;
    logic          cfg_we;
    logic [3:0]    init_state, left_s, ent_s, idx_s;
    logic          timed_s;

    // Configuration write on the access phase.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == tdf_pkg::REG_START_STATE);
    assign prdata = (paddr[2] == tdf_pkg::REG_START_STATE) ? {28'd0, init_state} : 32'd0;

    tdf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .i_action (s_tuser),
        .o_ready  (s_tready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    tdf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (s_tuser),
        .i_time_now      (s_tdata[31:0]),
        .i_event_code    (s_tdata[39:32]),
        .i_from_state    (s_tdata[43:40]),
        .i_to_state      (s_tdata[47:44]),
        .i_interval      (s_tdata[79:48]),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (pwdata[3:0]),
        .o_start_state   (init_state),
        .i_out_ready     (m_tready),
        .o_out_valid     (m_tvalid),
        .o_kind          (m_tuser),
        .o_left_state    (left_s),
        .o_entered_state (ent_s),
        .o_entry_index   (idx_s),
        .o_was_timed     (timed_s),
        .o_last          (m_tlast)
    );

    // Result fields packed from the lowest bit up.
    assign m_tdata = {3'd0, timed_s, idx_s, ent_s, left_s};

endmodule
`default_nettype wire

// ----- design/tdf_checker.sv -----
// Port checker for the table-driven state machine, bound to the top level.
`default_nettype none
module tdf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        pready
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset leaves no result on the output.
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // Appends finish in the cycle of their transfer.
    a_append_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser[1] |=> s_tready)
        else $error("append item held the input");

    // The configuration port never waits.
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind table_driven_fsm_with_timed_transitions tdf_checker u_tdf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the table-driven state machine with timed transitions.
`timescale 1ns / 1ps
module tb;

    // Expected result of one output transfer.
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] left_st;
        logic [3:0] entered_st;
        logic [3:0] index;
        logic       timed;
        logic       last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic [15:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    table_driven_fsm_with_timed_transitions i_dut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor copy of the machine.
    logic [3:0]  p_init_state;
    logic [3:0]  p_cur;
    logic        p_started;
    logic [3:0]  ev_src [tdf_pkg::EVENT_ENTRIES];
    logic [3:0]  ev_dst [tdf_pkg::EVENT_ENTRIES];
    logic [7:0]  ev_code [tdf_pkg::EVENT_ENTRIES];
    int          ev_num;
    logic [3:0]  tm_src [tdf_pkg::TIMED_ENTRIES];
    logic [3:0]  tm_dst [tdf_pkg::TIMED_ENTRIES];
    logic [31:0] tm_ivl [tdf_pkg::TIMED_ENTRIES];
    logic [31:0] tm_start [tdf_pkg::TIMED_ENTRIES];
    int          tm_num;

    t_result     pending_results[$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          trans_seen = 0;
    bit          sink_hold = 1'b0;
    bit          sink_fast = 1'b0;
    bit          src_fast = 1'b0;

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic void reset_model();
        p_init_state = '0;
        p_cur = '0;
        p_started = 1'b0;
        ev_num = 0;
        tm_num = 0;
        for (int i = 0; i < tdf_pkg::TIMED_ENTRIES; i++) tm_start[i] = '0;
    endfunction

    function automatic void push_result(input logic [1:0] k, input logic [3:0] l,
                                        input logic [3:0] e, input logic [3:0] x,
                                        input logic t, ref int n);
        t_result r;
        if (n >= tdf_pkg::MAX_RESULTS) return;
        r = '{k, l, e, x, t, 1'b0};
        pending_results.push_back(r);
        n++;
    endfunction

    function automatic void take_transition(input logic [3:0] src, input logic [3:0] dst,
                                            input int idx, input logic t,
                                            input logic [31:0] now, ref int n);
        push_result(tdf_pkg::KIND_TRANS, src, dst, 4'(idx), t, n);
        p_cur = dst;
        for (int i = 0; i < tm_num; i++)
            if (tm_src[i] == p_cur) tm_start[i] = now;
    endfunction

    // Work out the results of one accepted input item.
    function automatic void predict_item(input logic [1:0] act, input logic [31:0] now,
                                         input logic [7:0] code, input logic [3:0] src,
                                         input logic [3:0] dst, input logic [31:0] ivl);
        int n;
        t_result r;
        n = 0;
        case (act)
            tdf_pkg::ACT_RUN: begin
                if (!p_started) begin
                    p_started = 1'b1;
                    p_cur = p_init_state;
                    push_result(tdf_pkg::KIND_INIT, p_cur, p_cur, 4'd0, 1'b0, n);
                end
                push_result(tdf_pkg::KIND_ACTIV, p_cur, p_cur, 4'd0, 1'b0, n);
                for (int i = 0; i < tm_num; i++) begin
                    if (tm_src[i] != p_cur) continue;
                    if (tm_start[i] == 0) begin
                        tm_start[i] = now;
                    end else if (32'(now - tm_start[i]) >= tm_ivl[i]) begin
                        take_transition(tm_src[i], tm_dst[i], i, 1'b1, now, n);
                        tm_start[i] = '0;
                    end
                end
            end
            tdf_pkg::ACT_TRIGGER: begin
                if (p_started) begin
                    for (int i = 0; i < ev_num; i++) begin
                        if (ev_src[i] == p_cur && ev_code[i] == code) begin
                            take_transition(ev_src[i], ev_dst[i], i, 1'b0, now, n);
                            break;
                        end
                    end
                end
            end
            tdf_pkg::ACT_ADD_EV: begin
                if (ev_num < tdf_pkg::EVENT_ENTRIES) begin
                    ev_src[ev_num] = src;
                    ev_dst[ev_num] = dst;
                    ev_code[ev_num] = code;
                    ev_num++;
                end
            end
            default: begin
                if (tm_num < tdf_pkg::TIMED_ENTRIES) begin
                    tm_src[tm_num] = src;
                    tm_dst[tm_num] = dst;
                    tm_ivl[tm_num] = ivl;
                    tm_start[tm_num] = '0;
                    tm_num++;
                end
            end
        endcase
        if (n > 0) begin
            r = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endfunction

    // Random gap: mostly short, sometimes long.
    function automatic int gap_len(input bit fast);
        if (fast) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send one input item and predict its results at acceptance. The valid stays up
    // after the transfer so that the next item can follow without a gap.
    task automatic send_item(input logic [1:0] act, input logic [31:0] now,
                             input logic [7:0] code, input logic [3:0] src,
                             input logic [3:0] dst, input logic [31:0] ivl);
        int g;
        g = gap_len(src_fast);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {ivl, dst, src, code, now};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_item(act, now, code, src, dst, ivl);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Output side: random ready.
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            if (sink_hold) begin
                m_tready <= 1'b0;
            end else begin
                g = gap_len(sink_fast);
                if (g > 0) begin
                    m_tready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    // Each output transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report("result with nothing expected");
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r.kind == tdf_pkg::KIND_TRANS) trans_seen++;
                if (m_tuser != exp_r.kind) report("kind");
                if (m_tdata[3:0] != exp_r.left_st) report("left state");
                if (m_tdata[7:4] != exp_r.entered_st) report("entered state");
                if (m_tdata[11:8] != exp_r.index) report("entry index");
                if (m_tdata[12] != exp_r.timed) report("timed flag");
                if (m_tdata[15:13] != 3'b000) report("padding bits");
                if (m_tlast != exp_r.last) report("last flag");
            end
        end
    end

    // Stop offering items, then wait until every expected result has come.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // Register write over the configuration port and read back, only while idle.
    task automatic write_initial(input logic [3:0] st);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'({tdf_pkg::REG_START_STATE, 2'b00});
        pwdata <= 32'(st);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        p_init_state = st;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        psel <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[3:0] != st) report("register read back");
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Directed: triggers before start, table fill with extremes, overflowing appends.
    task automatic test_directed();
        write_initial(4'd15);
        send_item(tdf_pkg::ACT_TRIGGER, 32'd5, 8'd0, 4'd0, 4'd0, 32'd0);
        send_item(tdf_pkg::ACT_ADD_EV, 32'd0, 8'd255, 4'd15, 4'd0, 32'd0);
        send_item(tdf_pkg::ACT_ADD_EV, 32'd0, 8'd0, 4'd0, 4'd15, 32'd0);
        send_item(tdf_pkg::ACT_ADD_TM, 32'd0, 8'd0, 4'd15, 4'd15, 32'hFFFF_FFFF);
        send_item(tdf_pkg::ACT_ADD_TM, 32'd0, 8'd0, 4'd15, 4'd0, 32'd0);
        send_item(tdf_pkg::ACT_ADD_TM, 32'd0, 8'd0, 4'd0, 4'd15, 32'd10);
        send_item(tdf_pkg::ACT_RUN, 32'hFFFF_FFF0, 8'd0, 4'd0, 4'd0, 32'd0);
        send_item(tdf_pkg::ACT_RUN, 32'h0000_0005, 8'd0, 4'd0, 4'd0, 32'd0);
        send_item(tdf_pkg::ACT_RUN, 32'h0000_0100, 8'd0, 4'd0, 4'd0, 32'd0);
        send_item(tdf_pkg::ACT_TRIGGER, 32'd300, 8'd7, 4'd0, 4'd0, 32'd0);
        send_item(tdf_pkg::ACT_TRIGGER, 32'd301, 8'd0, 4'd0, 4'd0, 32'd0);
        send_item(tdf_pkg::ACT_TRIGGER, 32'd302, 8'd255, 4'd0, 4'd0, 32'd0);
        send_item(tdf_pkg::ACT_RUN, 32'd0, 8'd0, 4'd0, 4'd0, 32'd0);
        send_item(tdf_pkg::ACT_RUN, 32'hFFFF_FFFF, 8'd0, 4'd0, 4'd0, 32'd0);
        for (int i = 0; i < 6; i++)
            send_item(tdf_pkg::ACT_ADD_TM, 32'd0, 8'd0, 4'(i), 4'(i + 1), 32'd0);
        send_item(tdf_pkg::ACT_ADD_TM, 32'd0, 8'd0, 4'd1, 4'd2, 32'd1);
        wait_drained();
    endtask

    // Random traffic; the sender pauses for a full drain at the end.
    task automatic test_random(input int count);
        logic [1:0] act;
        logic [31:0] now, ivl;
        int r;
        now = $urandom;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            act = (r < 45) ? tdf_pkg::ACT_RUN : (r < 75) ? tdf_pkg::ACT_TRIGGER :
                  (r < 88) ? tdf_pkg::ACT_ADD_EV : tdf_pkg::ACT_ADD_TM;
            now = now + (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40));
            ivl = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60);
            send_item(act, now, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                      8'($urandom_range(0, 3)), 4'($urandom_range(0, 3)),
                      ($urandom_range(0, 4) == 0) ? 4'($urandom) :
                      4'($urandom_range(0, 3)), ivl);
        end
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering runs and triggers.
    task automatic test_backpressure();
        src_fast = 1'b1;
        fork
            begin
                sink_hold = 1'b1;
                repeat (400) @(negedge i_clk);
                sink_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 20; i++)
                    send_item((i % 2) ? tdf_pkg::ACT_TRIGGER : tdf_pkg::ACT_RUN,
                              32'(i * 50), 8'(i % 4), 4'd0, 4'd0, 32'd0);
                s_tvalid <= 1'b0;
            end
        join
        src_fast = 1'b0;
        sink_fast = 1'b1;
        test_random(20);
        sink_fast = 1'b0;
    endtask

    // Fresh machine after reset is not possible, so the first random phase uses a
    // small initial state; the directed test writes 15 and a later write sets 3.
    initial begin
        reset_model();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        write_initial(4'd0);
        test_random(100);
        write_initial(4'd3);
        test_backpressure();
        test_random(60);
        $display("Covered %0d input transfers and %0d output transfers (%0d transitions).",
                 items_sent, results_seen, trans_seen);
        $display("Configuration written with initial states 15, 0 and 3; output held off.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule
